// ===== sv/enbm_pkg.sv =====
// shared widths and codes for the edge-normalised 3x3 box mean
`default_nettype none

package enbm_pkg;

  // pixel and sum widths
  localparam int PIX_W     = 8;
  localparam int SUM_W     = PIX_W + 4;
  localparam int DIVR_W    = 4;
  // reciprocals are scaled by 2**RCP_SHIFT
  localparam int RCP_SHIFT = 16;

  // configuration port
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 13;
  localparam int FW_W      = 11;
  localparam int ROW_W     = 13;
  localparam int HEIGHT_LIMIT = 4096;
  localparam int HEIGHT_RESET = 1024;
  localparam int WIDTH_RESET  = 1024;
  localparam int MAX_WIDTH_DEFAULT = 1024;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

  // item kinds on the input tuser
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

endpackage

`default_nettype wire

// ===== sv/enbm_line_store.sv =====
// two line stores sharing one address, registered read
`default_nettype none

module enbm_line_store
  import enbm_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT,
  parameter int AW        = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [PIX_W-1:0] wr_upper,
  input  wire logic [PIX_W-1:0] wr_lower,
  output logic      [PIX_W-1:0] rd_upper,
  output logic      [PIX_W-1:0] rd_lower
);

  logic [PIX_W-1:0] upper_mem [MAX_WIDTH];
  logic [PIX_W-1:0] lower_mem [MAX_WIDTH];
  logic [PIX_W-1:0] rd_upper_r;
  logic [PIX_W-1:0] rd_lower_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      upper_mem[wr_addr] <= wr_upper;
      lower_mem[wr_addr] <= wr_lower;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_upper_r <= upper_mem[rd_addr];
      rd_lower_r <= lower_mem[rd_addr];
    end
  end

  assign rd_upper = rd_upper_r;
  assign rd_lower = rd_lower_r;

endmodule

`default_nettype wire

// ===== sv/enbm_div.sv =====
// mean of the window sum by reciprocal multiplication, two register stages
`default_nettype none

module enbm_div
  import enbm_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [SUM_W-1:0]  dividend,
  input  wire logic [DIVR_W-1:0] divisor,
  output logic                   done,
  output logic      [PIX_W-1:0]  quotient
);

  localparam int RCP_W  = RCP_SHIFT + 1;
  localparam int PROD_W = SUM_W + RCP_W;

  logic [SUM_W-1:0]  dvd_r;
  logic [RCP_W-1:0]  rcp_r, rcp_nxt;
  logic              pend_r;
  logic              done_r;
  logic [PIX_W-1:0]  quo_r;
  logic [PROD_W-1:0] prod;

  // rounded-up reciprocal of the place count; exact for every window sum
  always_comb begin
    unique case (divisor)
      DIVR_W'(1): rcp_nxt = RCP_W'(65536);
      DIVR_W'(2): rcp_nxt = RCP_W'(32768);
      DIVR_W'(3): rcp_nxt = RCP_W'(21846);
      DIVR_W'(4): rcp_nxt = RCP_W'(16384);
      DIVR_W'(6): rcp_nxt = RCP_W'(10923);
      DIVR_W'(9): rcp_nxt = RCP_W'(7282);
      default:    rcp_nxt = '0;
    endcase
  end

  // stage one: hold the sum and the reciprocal
  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      rcp_r <= rcp_nxt;
    end
  end

  assign prod = PROD_W'(dvd_r) * PROD_W'(rcp_r);

  // stage two: scale the product back to the quotient
  always_ff @(posedge clk) begin
    if (pend_r) begin
      quo_r <= prod[RCP_SHIFT +: PIX_W];
    end
  end

  // result flag, low from start until the quotient is ready
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      pend_r <= start;
      if (start) begin
        done_r <= 1'b0;
      end else if (pend_r) begin
        done_r <= 1'b1;
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

// ===== sv/edge_normalized_box_mean_3x3.sv =====
// Streaming 3x3 box mean with edge normalisation.
// Pixels of a frame enter on the in_ channel in raster order, one per beat,
// in_tuser marking a drain beat (no pixel). After the last pixel the host
// sends frame_width+1 drain beats to flush the final row. Each position's
// result leaves on the out_ channel once the beat one row down and one
// column right has arrived; out_tlast marks the frame's final position.
// frame_width and frame_height are written on the cfg_ channel (index 0 and
// 1); the host must write them only while the block is idle, which the
// block does not enforce. Any write restarts the frame. An ignored drain
// beat is taken in idle with no further work; any other beat goes through
// the line store read, then window update and write back, and, if it yields
// a result, the window sum and the mean by reciprocal multiplication before
// the result is registered on out_tvalid; only then is a new beat taken.
// The line stores sit in one memory block with a registered read port.
// Reset clears the counters and window, sets height to 1024 and width to
// 1024 (MAX_WIDTH if smaller); the line stores are not cleared. A result
// waits in the output register while the receiver stalls; the next beat is
// still taken, and its own result waits in the divider until it frees.
`default_nettype none

module edge_normalized_box_mean_3x3
  import enbm_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // input stream
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire logic [7:0]           in_tdata,   // [7:0] pixel_value
  input  wire logic                 in_tuser,   // [0] operation
  // result stream
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  output logic      [7:0]           out_tdata,  // [7:0] mean_value
  output logic                      out_tlast,
  // configuration writes
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_DAT_W-1:0] cfg_data
);

  localparam int AW     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int EW_W   = $clog2(MAX_WIDTH + 1) + 1;
  localparam int W_RST  = (MAX_WIDTH < WIDTH_RESET) ? MAX_WIDTH : WIDTH_RESET;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_READ = 4'b0010,
    S_SUM  = 4'b0100,
    S_DIV  = 4'b1000
  } state_t;

  state_t             state_r, state_nxt;
  logic [EW_W-1:0]    w_r, w_nxt;
  logic [ROW_W-1:0]   h_r, h_nxt;
  logic [AW-1:0]      col_r, col_nxt;
  logic [ROW_W-1:0]   row_r, row_nxt;
  logic [PIX_W-1:0]   pix_r, pix_nxt;
  logic [PIX_W-1:0]   win_r   [3][3];
  logic [PIX_W-1:0]   win_nxt [3][3];
  logic [2:0]         rmask_r, rmask_nxt;
  logic [2:0]         cmask_r, cmask_nxt;
  logic               last_r, last_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [PIX_W-1:0]   out_data_r, out_data_nxt;
  logic               out_last_r, out_last_nxt;

  logic               in_fire;
  logic               cfg_fire;
  logic               in_frame;
  logic               ignore_beat;
  logic               col_end;
  logic               emit;
  logic [ROW_W-1:0]   cr;
  logic [AW-1:0]      cc;
  logic               is_last;
  logic               out_free;
  logic [SUM_W-1:0]   win_sum;
  logic [DIVR_W-1:0]  win_cnt;
  logic               div_start;
  logic               div_done;
  logic [PIX_W-1:0]   div_quo;
  logic               mem_rd_en;
  logic               mem_wr_en;
  logic [PIX_W-1:0]   mem_upper;
  logic [PIX_W-1:0]   mem_lower;

  // count of in-frame places for the row and column masks
  function automatic logic [DIVR_W-1:0] place_count(input logic [2:0] rm,
                                                    input logic [2:0] cm);
    logic [1:0] nr;
    logic [1:0] nc;
    nr = 2'(rm[0]) + 2'(rm[1]) + 2'(rm[2]);
    nc = 2'(cm[0]) + 2'(cm[1]) + 2'(cm[2]);
    return DIVR_W'(nr) * DIVR_W'(nc);
  endfunction

  assign in_tready = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_fire   = in_tvalid && in_tready;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign out_free  = !out_valid_r || out_tready;

  assign in_frame    = (row_r < h_r);
  assign ignore_beat = (in_tuser == OP_DRAIN) && in_frame;

  // output position and last flag for the current beat
  always_comb begin
    col_end = (EW_W'(col_r) == w_r - 1'b1);
    emit    = (row_r >= ROW_W'(2)) || ((row_r == ROW_W'(1)) && (col_r != '0));
    if (col_r != '0) begin
      cr = row_r - 1'b1;
      cc = col_r - 1'b1;
    end else begin
      cr = row_r - ROW_W'(2);
      cc = AW'(w_r - 1'b1);
    end
    is_last = emit && (cr == h_r - 1'b1) && (EW_W'(cc) == w_r - 1'b1);
  end

  // masked window sum
  always_comb begin
    win_sum = '0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        if (rmask_r[i] && cmask_r[j]) begin
          win_sum = win_sum + SUM_W'(win_r[i][j]);
        end
      end
    end
    win_cnt = place_count(rmask_r, cmask_r);
  end

  // controller and datapath next values
  always_comb begin
    state_nxt     = state_r;
    w_nxt         = w_r;
    h_nxt         = h_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    pix_nxt       = pix_r;
    win_nxt       = win_r;
    rmask_nxt     = rmask_r;
    cmask_nxt     = cmask_r;
    last_nxt      = last_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    mem_rd_en     = 1'b0;
    mem_wr_en     = 1'b0;
    div_start     = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire && !ignore_beat) begin
          mem_rd_en = 1'b1;
          pix_nxt   = in_frame ? in_tdata : '0;
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        // shift window, write line stores back
        for (int r = 0; r < 3; r++) begin
          win_nxt[r][0] = win_r[r][1];
          win_nxt[r][1] = win_r[r][2];
        end
        win_nxt[0][2] = mem_upper;
        win_nxt[1][2] = mem_lower;
        win_nxt[2][2] = pix_r;
        mem_wr_en     = 1'b1;
        rmask_nxt = {(cr + 1'b1 < h_r), 1'b1, (cr != '0)};
        cmask_nxt = {(EW_W'(cc) + 1'b1 < w_r), 1'b1, (cc != '0)};
        last_nxt  = is_last;
        if (is_last) begin
          col_nxt = '0;
          row_nxt = '0;
        end else if (col_end) begin
          col_nxt = '0;
          row_nxt = row_r + 1'b1;
        end else begin
          col_nxt = col_r + 1'b1;
        end
        state_nxt = emit ? S_SUM : S_IDLE;
      end
      S_SUM: begin
        div_start = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (div_done && out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = div_quo;
          out_last_nxt  = last_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // register writes restart the frame
    if (cfg_fire) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH: begin
          if (cfg_data[FW_W-1:0] == '0) begin
            w_nxt = EW_W'(1);
          end else if (32'(cfg_data[FW_W-1:0]) > 32'(MAX_WIDTH)) begin
            w_nxt = EW_W'(MAX_WIDTH);
          end else begin
            w_nxt = EW_W'(cfg_data[FW_W-1:0]);
          end
        end
        REG_FRAME_HEIGHT: begin
          if (cfg_data[ROW_W-1:0] == '0) begin
            h_nxt = ROW_W'(1);
          end else if (32'(cfg_data[ROW_W-1:0]) > 32'(HEIGHT_LIMIT)) begin
            h_nxt = ROW_W'(HEIGHT_LIMIT);
          end else begin
            h_nxt = cfg_data[ROW_W-1:0];
          end
        end
        default: ;
      endcase
      col_nxt = '0;
      row_nxt = '0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      w_r         <= EW_W'(W_RST);
      h_r         <= ROW_W'(HEIGHT_RESET);
      col_r       <= '0;
      row_r       <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          win_r[i][j] <= '0;
        end
      end
    end else begin
      state_r     <= state_nxt;
      w_r         <= w_nxt;
      h_r         <= h_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      out_valid_r <= out_valid_nxt;
      win_r       <= win_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    pix_r      <= pix_nxt;
    rmask_r    <= rmask_nxt;
    cmask_r    <= cmask_nxt;
    last_r     <= last_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

  // line stores, read and written at the current column
  enbm_line_store #(
    .MAX_WIDTH (MAX_WIDTH),
    .AW        (AW)
  ) u_line_store (
    .clk      (clk),
    .rd_en    (mem_rd_en),
    .rd_addr  (col_r),
    .wr_en    (mem_wr_en),
    .wr_addr  (col_r),
    .wr_upper (mem_lower),
    .wr_lower (pix_r),
    .rd_upper (mem_upper),
    .rd_lower (mem_lower)
  );

  // mean by reciprocal multiplication
  enbm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (win_sum),
    .divisor  (win_cnt),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire
